### hdl/sha1md_pkg.sv
package sha1md_pkg;

  localparam int unsigned ROUNDS = 80;
  localparam int unsigned NUM_WORDS = 5;

  localparam logic [2:0] LAST_WORD = 3'(NUM_WORDS - 1);

  localparam logic [31:0] H_INIT [NUM_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [31:0] K_CH  = 32'h5A827999;
  localparam logic [31:0] K_PA1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_MAJ = 32'h8F1BBCDC;
  localparam logic [31:0] K_PA2 = 32'hCA62C1D6;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  // round group: selects f and k
  typedef enum logic [1:0] {
    RG_CH,
    RG_PAR1,
    RG_MAJ,
    RG_PAR2
  } rgrp_e;

  typedef struct packed {
    logic       load_byte;
    logic       pad;
    logic       len_wr;
    logic       len_clr;
    logic       wv_load;
    logic       round_en;
    rgrp_e      grp;
    logic       fold;
    logic       reinit;
    logic [2:0] sel;
  } dp_cmd_t;

  typedef struct packed {
    logic pos_last;  // block position is 63
    logic pos_hi;    // block position is 56 or more
  } dp_sts_t;

endpackage

### hdl/sha1md_dp.sv
module sha1md_dp import sha1md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  input  logic [7:0]  data_byte_i,
  output dp_sts_t     sts_o,
  output logic [31:0] digest_word_o
);

  logic [31:0] blk_q [16];
  logic [31:0] h_q [NUM_WORDS];
  logic [31:0] wv_q [NUM_WORDS];
  logic [60:0] cnt_q;

  logic [3:0]  wi;
  logic [1:0]  lane;
  logic [4:0]  sh;
  logic [7:0]  wr_byte;
  logic [63:0] bits;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [31:0] f;
  logic [31:0] k;
  logic [31:0] temp;

  assign wi      = cnt_q[5:2];
  assign lane    = cnt_q[1:0];
  assign sh      = {~lane, 3'b000};
  assign wr_byte = cmd_i.load_byte ? data_byte_i : PAD_BYTE;
  assign bits    = {cnt_q, 3'b000};

  assign sts_o.pos_last = (cnt_q[5:0] == 6'h3F);
  assign sts_o.pos_hi   = (cnt_q[5:3] == 3'b111);

  // schedule window: blk_q[0] is the word used this round
  assign w_mix = blk_q[13] ^ blk_q[8] ^ blk_q[2] ^ blk_q[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  always_comb begin
    case (cmd_i.grp)
      RG_CH: begin
        f = (wv_q[1] & wv_q[2]) | (~wv_q[1] & wv_q[3]);
        k = K_CH;
      end
      RG_PAR1: begin
        f = wv_q[1] ^ wv_q[2] ^ wv_q[3];
        k = K_PA1;
      end
      RG_MAJ: begin
        f = (wv_q[1] & wv_q[2]) | (wv_q[1] & wv_q[3]) | (wv_q[2] & wv_q[3]);
        k = K_MAJ;
      end
      default: begin
        f = wv_q[1] ^ wv_q[2] ^ wv_q[3];
        k = K_PA2;
      end
    endcase
  end

  assign temp = {wv_q[0][26:0], wv_q[0][31:27]} + f + wv_q[4] + k + blk_q[0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_byte || cmd_i.pad) begin
      for (int i = 0; i < 16; i++) begin
        if (4'(i) == wi) begin
          if (lane == 2'd0) begin
            blk_q[i] <= {wr_byte, 24'h000000};
          end else begin
            blk_q[i][sh +: 8] <= wr_byte;
          end
        end else if (cmd_i.pad && (4'(i) > wi)) begin
          blk_q[i] <= '0;
        end
      end
    end else if (cmd_i.len_wr) begin
      for (int i = 0; i < 14; i++) begin
        if (cmd_i.len_clr) begin
          blk_q[i] <= '0;
        end
      end
      blk_q[14] <= bits[63:32];
      blk_q[15] <= bits[31:0];
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        blk_q[i] <= blk_q[i+1];
      end
      blk_q[15] <= w_new;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wv_load) begin
      for (int i = 0; i < NUM_WORDS; i++) begin
        wv_q[i] <= h_q[i];
      end
    end else if (cmd_i.round_en) begin
      wv_q[4] <= wv_q[3];
      wv_q[3] <= wv_q[2];
      wv_q[2] <= {wv_q[1][1:0], wv_q[1][31:2]};
      wv_q[1] <= wv_q[0];
      wv_q[0] <= temp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_q[i] <= H_INIT[i];
      end
    end else if (cmd_i.reinit) begin
      cnt_q <= '0;
      for (int i = 0; i < NUM_WORDS; i++) begin
        h_q[i] <= H_INIT[i];
      end
    end else begin
      if (cmd_i.load_byte) begin
        cnt_q <= cnt_q + 61'd1;
      end
      if (cmd_i.fold) begin
        for (int i = 0; i < NUM_WORDS; i++) begin
          h_q[i] <= h_q[i] + wv_q[i];
        end
      end
    end
  end

  always_comb begin
    case (cmd_i.sel)
      3'd0:    digest_word_o = h_q[0];
      3'd1:    digest_word_o = h_q[1];
      3'd2:    digest_word_o = h_q[2];
      3'd3:    digest_word_o = h_q[3];
      3'd4:    digest_word_o = h_q[4];
      default: digest_word_o = '0;
    endcase
  end

endmodule

### hdl/sha1md_ctrl.sv
module sha1md_ctrl import sha1md_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       byte_present_i,
  input  logic       end_of_message_i,
  input  logic       out_ready_i,
  input  dp_sts_t    sts_i,
  output dp_cmd_t    cmd_o,
  output logic       in_ready_o,
  output logic       out_valid_o,
  output logic [2:0] word_index_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_LEN,
    S_LOAD,
    S_ROUND,
    S_FOLD,
    S_OUT
  } state_e;

  // what follows the compression in flight
  typedef enum logic [1:0] {
    A_DATA,
    A_PAD1,
    A_FINAL
  } after_e;

  state_e     state_q;
  after_e     after_q;
  logic       end_q;
  logic       clr_q;
  logic [6:0] round_q;
  logic [2:0] idx_q;

  logic in_acc;
  logic out_acc;

  assign in_acc       = (state_q == S_IDLE) && in_valid_i;
  assign out_acc      = (state_q == S_OUT) && out_ready_i;
  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = (state_q == S_OUT);
  assign word_index_o = idx_q;

  always_comb begin
    cmd_o           = '0;
    cmd_o.load_byte = in_acc && byte_present_i;
    cmd_o.pad       = (state_q == S_PAD);
    cmd_o.len_wr    = (state_q == S_LEN);
    cmd_o.len_clr   = clr_q;
    cmd_o.wv_load   = (state_q == S_LOAD);
    cmd_o.round_en  = (state_q == S_ROUND);
    cmd_o.fold      = (state_q == S_FOLD);
    cmd_o.reinit    = out_acc && (idx_q == LAST_WORD);
    cmd_o.sel       = idx_q;
    if (round_q < 7'd20) begin
      cmd_o.grp = RG_CH;
    end else if (round_q < 7'd40) begin
      cmd_o.grp = RG_PAR1;
    end else if (round_q < 7'd60) begin
      cmd_o.grp = RG_MAJ;
    end else begin
      cmd_o.grp = RG_PAR2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      after_q <= A_DATA;
      end_q   <= 1'b0;
      clr_q   <= 1'b0;
      round_q <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            end_q <= end_of_message_i;
            if (byte_present_i && sts_i.pos_last) begin
              after_q <= A_DATA;
              state_q <= S_LOAD;
            end else if (end_of_message_i) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (sts_i.pos_hi) begin
            clr_q   <= 1'b1;
            after_q <= A_PAD1;
            state_q <= S_LOAD;
          end else begin
            clr_q   <= 1'b0;
            state_q <= S_LEN;
          end
        end
        S_LEN: begin
          after_q <= A_FINAL;
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          round_q <= '0;
          state_q <= S_ROUND;
        end
        S_ROUND: begin
          round_q <= round_q + 7'd1;
          if (round_q == 7'(ROUNDS - 1)) begin
            state_q <= S_FOLD;
          end
        end
        S_FOLD: begin
          unique case (after_q)
            A_DATA:  state_q <= end_q ? S_PAD : S_IDLE;
            A_PAD1:  state_q <= S_LEN;
            A_FINAL: begin
              idx_q   <= '0;
              state_q <= S_OUT;
            end
            default: state_q <= S_IDLE;
          endcase
        end
        S_OUT: begin
          if (out_ready_i) begin
            if (idx_q == LAST_WORD) begin
              idx_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q <= idx_q + 3'd1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/sha1_message_digest_unit.sv
// SHA-1 digest engine, one message byte per input transaction.
// Input channel (in_valid_i / in_ready_o): data_byte_i is taken in when
// byte_present_i is set; end_of_message_i marks the last transaction of a
// message, which may carry no byte so that an empty message can be hashed.
// Output channel (out_valid_o / out_ready_i): five transactions per message,
// h0 first, word_index_o counting 0..4 and last_word_o set on h4.
// A byte that fills a 64-byte block keeps the input busy for one accept, one
// load, the 80 rounds of the single shared round unit and one fold into the
// chaining words. After the end transaction the tail runs one pad, one length
// write and one compression, or a second compression and tail block when
// the length does not fit, before the first digest word is shown.
// Input is held off while a block compresses and while the digest goes out;
// a stalled receiver holds the current word steady and the block just waits.
// After the fifth word the chaining words and byte count return to their
// initial values, ready for the next message. Reset does the same at once.
module sha1_message_digest_unit import sha1md_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  sha1md_ctrl u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .byte_present_i   (byte_present_i),
    .end_of_message_i (end_of_message_i),
    .out_ready_i      (out_ready_i),
    .sts_i            (sts),
    .cmd_o            (cmd),
    .in_ready_o       (in_ready_o),
    .out_valid_o      (out_valid_o),
    .word_index_o     (word_index_o)
  );

  sha1md_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (data_byte_i),
    .sts_o         (sts),
    .digest_word_o (digest_word_o)
  );

  assign last_word_o = (word_index_o == LAST_WORD);

endmodule
